FILE: hdl/sdfc_pkg.sv
// shared types and constants for the sonar datagram frame checker
`default_nettype none

package sdfc_pkg;

   // field widths
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 20;             // max_length register width
   localparam int POS_W    = LEN_W + 1;      // holds positions up to max length + 3
   localparam int FLEN_W   = 32;             // length field as received
   localparam int SUM_W    = 16;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W = 2;

   // header capture
   localparam int HDR_BYTES = 15;
   localparam int HDR_IDX_W = $clog2(HDR_BYTES);

   // stream positions
   localparam logic [POS_W-1:0] LEN_LAST_POS = POS_W'(3);
   localparam logic [POS_W-1:0] START_POS    = POS_W'(4);
   localparam logic [POS_W-1:0] HDR_FIRST    = POS_W'(5);
   localparam logic [POS_W-1:0] HDR_END      = POS_W'(5 + HDR_BYTES);
   localparam logic [FLEN_W-1:0] MIN_LENGTH  = FLEN_W'(4);

   // frame status codes
   localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_START  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_END    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_SUM    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_BAD_LENGTH = 3'd4;

   // register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_START_MARKER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_MARKER   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH   = 2'd2;

   localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'd2;
   localparam logic [BYTE_W-1:0] END_MARKER_RESET   = 8'd3;
   localparam logic [LEN_W-1:0]  MAX_LENGTH_RESET   = 20'd128000;

   typedef struct packed {
      logic [STATUS_W-1:0] frame_status;
      logic [7:0]          datagram_id;
      logic [15:0]         model_number;
      logic [31:0]         date_word;
      logic [31:0]         millisecond_word;
      logic [15:0]         ping_number;
      logic [15:0]         serial_word;
      logic [FLEN_W-1:0]   frame_length;
      logic [SUM_W-1:0]    computed_sum;
   } sdfc_result_type;

   typedef struct packed {
      logic [BYTE_W-1:0] start_marker;
      logic [BYTE_W-1:0] end_marker;
      logic [LEN_W-1:0]  max_length;
   } sdfc_csr_type;

endpackage

`default_nettype wire

FILE: hdl/sdfc_frame_tracker.sv
// framing state, running checksum and header capture, one byte per cycle while consume is high
`default_nettype none

module sdfc_frame_tracker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           consume,
   input  wire logic [sdfc_pkg::BYTE_W-1:0]    data_byte,
   input  wire sdfc_pkg::sdfc_csr_type         csr,
   output      logic                           done,
   output      sdfc_pkg::sdfc_result_type      result
);
   import sdfc_pkg::*;

   logic [POS_W-1:0]              pos_ff, pos_in;
   logic [FLEN_W-1:0]             len_ff, len_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic                          start_ok_ff, start_ok_in;
   logic                          end_ok_ff, end_ok_in;
   logic [BYTE_W-1:0]             sum_low_ff, sum_low_in;
   logic [HDR_BYTES-1:0][7:0]     hdr_ff, hdr_in;

   logic [FLEN_W-1:0]             len_acc;
   logic [POS_W-1:0]              len_pos;
   logic [POS_W-1:0]              hdr_off;
   logic [HDR_IDX_W-1:0]          hdr_idx;
   logic [SUM_W-1:0]              recv_sum;

   assign len_pos  = POS_W'(len_ff[LEN_W-1:0]);
   assign hdr_off  = pos_ff - HDR_FIRST;
   assign hdr_idx  = hdr_off[HDR_IDX_W-1:0];
   assign recv_sum = {data_byte, sum_low_ff};

   always_comb begin
      pos_in      = pos_ff;
      len_in      = len_ff;
      sum_in      = sum_ff;
      start_ok_in = start_ok_ff;
      end_ok_in   = end_ok_ff;
      sum_low_in  = sum_low_ff;
      hdr_in      = hdr_ff;
      len_acc     = len_ff;
      done        = 1'b0;
      result      = '0;

      if (consume) begin
         if (pos_ff < START_POS) begin
            // length field, little-endian
            if (pos_ff == '0) begin
               len_acc     = '0;
               sum_in      = '0;
               start_ok_in = 1'b0;
               end_ok_in   = 1'b0;
               sum_low_in  = '0;
               hdr_in      = '0;
            end
            case (pos_ff[1:0])
               2'd0:    len_acc[7:0]   = data_byte;
               2'd1:    len_acc[15:8]  = data_byte;
               2'd2:    len_acc[23:16] = data_byte;
               default: len_acc[31:24] = data_byte;
            endcase
            len_in = len_acc;
            if (pos_ff == LEN_LAST_POS &&
                (len_acc < MIN_LENGTH ||
                 len_acc > FLEN_W'(csr.max_length))) begin
               done                = 1'b1;
               result.frame_status = STATUS_BAD_LENGTH;
               result.frame_length = len_acc;
               pos_in              = '0;
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end else begin
            if (pos_ff == START_POS) begin
               start_ok_in = (data_byte == csr.start_marker);
            end
            if (pos_ff >= HDR_FIRST && pos_ff <= len_pos) begin
               sum_in = sum_ff + SUM_W'(data_byte);
               if (pos_ff < HDR_END) begin
                  hdr_in[hdr_idx] = data_byte;
               end
            end
            if (pos_ff == len_pos + POS_W'(1)) begin
               end_ok_in = (data_byte == csr.end_marker);
            end
            if (pos_ff == len_pos + POS_W'(2)) begin
               sum_low_in = data_byte;
            end
            if (pos_ff == len_pos + POS_W'(3)) begin
               done = 1'b1;
               if (!start_ok_ff) begin
                  result.frame_status = STATUS_BAD_START;
               end else if (!end_ok_ff) begin
                  result.frame_status = STATUS_BAD_END;
               end else if (recv_sum != sum_ff) begin
                  result.frame_status = STATUS_BAD_SUM;
               end else begin
                  result.frame_status = STATUS_OK;
               end
               result.datagram_id      = hdr_ff[0];
               result.model_number     = {hdr_ff[2], hdr_ff[1]};
               result.date_word        = {hdr_ff[6], hdr_ff[5], hdr_ff[4], hdr_ff[3]};
               result.millisecond_word = {hdr_ff[10], hdr_ff[9], hdr_ff[8], hdr_ff[7]};
               result.ping_number      = {hdr_ff[12], hdr_ff[11]};
               result.serial_word      = {hdr_ff[14], hdr_ff[13]};
               result.frame_length     = len_ff;
               result.computed_sum     = sum_ff;
               pos_in                  = '0;
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         len_ff      <= '0;
         sum_ff      <= '0;
         start_ok_ff <= 1'b0;
         end_ok_ff   <= 1'b0;
         sum_low_ff  <= '0;
         hdr_ff      <= '0;
      end else begin
         pos_ff      <= pos_in;
         len_ff      <= len_in;
         sum_ff      <= sum_in;
         start_ok_ff <= start_ok_in;
         end_ok_ff   <= end_ok_in;
         sum_low_ff  <= sum_low_in;
         hdr_ff      <= hdr_in;
      end
   end

`ifndef SYNTHESIS
   // a body is only entered with an accepted length
   a_body_len_valid: assert property (@(posedge clock) disable iff (reset)
      pos_ff > LEN_LAST_POS |-> len_ff >= MIN_LENGTH && len_ff[FLEN_W-1:LEN_W] == '0)
      else $error("body position with out-of-range length");

   // position never runs past the last checksum byte
   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      pos_ff > LEN_LAST_POS |-> pos_ff <= len_pos + POS_W'(3))
      else $error("byte position past end of datagram");
`endif

endmodule

`default_nettype wire

FILE: hdl/sdfc_result_reg.sv
// result register with valid/stall output handshake
`default_nettype none

module sdfc_result_reg (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      load,
   input  wire sdfc_pkg::sdfc_result_type result_in,
   input  wire logic                      rsp_stall,
   output      logic                      rsp_valid,
   output      sdfc_pkg::sdfc_result_type result_out,
   output      logic                      free
);
   import sdfc_pkg::*;

   logic            valid_ff, valid_in;
   sdfc_result_type data_ff;

   // slot can take a new result when empty or being drained this cycle
   assign free      = !valid_ff || !rsp_stall;
   assign valid_in  = load || (valid_ff && rsp_stall);
   assign rsp_valid = valid_ff;
   assign result_out = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result_in;
      end
   end

`ifndef SYNTHESIS
   // a bad length result carries only the length field
   a_bad_len_clean: assert property (@(posedge clock) disable iff (reset)
      valid_ff && data_ff.frame_status == STATUS_BAD_LENGTH |->
         data_ff.datagram_id == '0 && data_ff.computed_sum == '0 &&
         data_ff.date_word == '0)
      else $error("bad length result with header data");
`endif

endmodule

`default_nettype wire

FILE: hdl/sonar_datagram_frame_checker_top.sv
// top level of the sonar datagram frame checker
//
// usage
// - req channel: one stream byte per transfer on req_data_byte (req_valid/req_stall)
// - rsp channel: one result per finished or rejected datagram (rsp_valid/rsp_stall)
// - csr port: csr_write_enable with csr_index 0 start marker, 1 end marker,
//   2 max length; written while the block is idle, takes effect at once
// result path: a result is offered on rsp once the byte that ends it has passed
//   the input register, then the frame tracker into the result register
// throughput: one byte per cycle while the result slot is free;
//   a byte that ends a datagram yields its result with no gap
// reset: synchronous, clears framing (next byte is the first length byte),
//   both pipeline valids, and loads marker 2, end marker 3, max length 128000
// stall: while rsp_stall holds a waiting result, the input register holds
//   its byte and req_stall rises only if that register is full; bytes that
//   produce no result still wait, so no transfer is ever lost or repeated
// bad length: a length below 4 or above max length gives a status 4 result
//   on its fourth byte and the following byte starts a new length field
`default_nettype none

module sonar_datagram_frame_checker_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input byte stream
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire logic [7:0]                      req_data_byte,
   // results
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      logic [2:0]                      rsp_frame_status,
   output      logic [7:0]                      rsp_datagram_id,
   output      logic [15:0]                     rsp_model_number,
   output      logic [31:0]                     rsp_date_word,
   output      logic [31:0]                     rsp_millisecond_word,
   output      logic [15:0]                     rsp_ping_number,
   output      logic [15:0]                     rsp_serial_word,
   output      logic [31:0]                     rsp_frame_length,
   output      logic [15:0]                     rsp_computed_sum,
   // configuration writes
   input  wire logic                            csr_write_enable,
   input  wire logic [sdfc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sdfc_pkg::LEN_W-1:0]      csr_write_data
);
   import sdfc_pkg::*;

   // configuration registers
   sdfc_csr_type      csr_ff;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;

   logic              req_xfer;
   logic              consume;
   logic              out_free;
   logic              done;
   sdfc_result_type   result;
   sdfc_result_type   rsp_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.start_marker <= START_MARKER_RESET;
         csr_ff.end_marker   <= END_MARKER_RESET;
         csr_ff.max_length   <= MAX_LENGTH_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_START_MARKER: csr_ff.start_marker <= csr_write_data[BYTE_W-1:0];
            CSR_END_MARKER:   csr_ff.end_marker   <= csr_write_data[BYTE_W-1:0];
            CSR_MAX_LENGTH:   csr_ff.max_length   <= csr_write_data;
            default: ;       // unused index, write dropped
         endcase
      end
   end

   // the held byte moves on whenever the result slot can take an outcome
   assign consume     = in_valid_ff && out_free;
   assign req_stall   = in_valid_ff && !out_free;
   assign req_xfer    = req_valid && !req_stall;
   assign in_valid_in = req_xfer || (in_valid_ff && !out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_data_byte;
      end
   end

   sdfc_frame_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .consume   (consume),
      .data_byte (in_byte_ff),
      .csr       (csr_ff),
      .done      (done),
      .result    (result)
   );

   sdfc_result_reg u_result (
      .clock      (clock),
      .reset      (reset),
      .load       (consume && done),
      .result_in  (result),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .result_out (rsp_result),
      .free       (out_free)
   );

   // unpack result fields onto their ports
   assign rsp_frame_status     = rsp_result.frame_status;
   assign rsp_datagram_id      = rsp_result.datagram_id;
   assign rsp_model_number     = rsp_result.model_number;
   assign rsp_date_word        = rsp_result.date_word;
   assign rsp_millisecond_word = rsp_result.millisecond_word;
   assign rsp_ping_number      = rsp_result.ping_number;
   assign rsp_serial_word      = rsp_result.serial_word;
   assign rsp_frame_length     = rsp_result.frame_length;
   assign rsp_computed_sum     = rsp_result.computed_sum;

endmodule

`default_nettype wire

FILE: bench/sonar_datagram_frame_checker_top_tb.sv
// self-checking testbench for the sonar datagram frame checker top level
`default_nettype none

module sonar_datagram_frame_checker_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sdfc_pkg::*;

   // clock, reset and block ports
   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [7:0]           req_data_byte;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [2:0]           rsp_frame_status;
   logic [7:0]           rsp_datagram_id;
   logic [15:0]          rsp_model_number;
   logic [31:0]          rsp_date_word;
   logic [31:0]          rsp_millisecond_word;
   logic [15:0]          rsp_ping_number;
   logic [15:0]          rsp_serial_word;
   logic [31:0]          rsp_frame_length;
   logic [15:0]          rsp_computed_sum;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [LEN_W-1:0]     csr_write_data;

   sonar_datagram_frame_checker_top u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_byte        (req_data_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_frame_status     (rsp_frame_status),
      .rsp_datagram_id      (rsp_datagram_id),
      .rsp_model_number     (rsp_model_number),
      .rsp_date_word        (rsp_date_word),
      .rsp_millisecond_word (rsp_millisecond_word),
      .rsp_ping_number      (rsp_ping_number),
      .rsp_serial_word      (rsp_serial_word),
      .rsp_frame_length     (rsp_frame_length),
      .rsp_computed_sum     (rsp_computed_sum),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   // stream bytes waiting for the driver, and frame results still to arrive
   logic [7:0]      stream_bytes[$];
   sdfc_result_type frame_results[$];
   int              bytes_queued;
   int              mismatch_count;

   // shadow of the configuration registers
   logic [7:0]       cfg_start;
   logic [7:0]       cfg_end;
   logic [LEN_W-1:0] cfg_max;

   // shadow framing state, tracked on every accepted byte
   int unsigned trk_pos;
   logic [31:0] trk_len;
   logic [15:0] trk_sum;
   logic        trk_start_ok;
   logic        trk_end_ok;
   logic [7:0]  trk_sum_low;
   logic [7:0]  trk_hdr[HDR_BYTES];

   // driver and receiver pacing state
   logic        req_taken;
   int          burst_left;
   int          gap_left;
   int          stall_mode;
   int          stall_mode_left;
   sdfc_result_type wanted_result;
   int          phase;
   int          phase_target;
   logic [7:0]  new_start;
   logic [7:0]  new_end;
   logic [LEN_W-1:0] new_max;

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // generous run limit, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // frame tracker: works out the result, if any, that one byte causes
   // ---------------------------------------------------------------------
   task automatic track_byte(input logic [7:0] b);
      sdfc_result_type res;
      logic [15:0]     recv;
      res = '0;
      if (trk_pos < 4) begin
         // length field, little-endian; state cleared on its first byte
         if (trk_pos == 0) begin
            trk_len      = '0;
            trk_sum      = '0;
            trk_start_ok = 1'b0;
            trk_end_ok   = 1'b0;
            trk_sum_low  = '0;
            foreach (trk_hdr[i]) trk_hdr[i] = '0;
         end
         trk_len = trk_len | (32'(b) << (8 * trk_pos));
         if (trk_pos == LEN_LAST_POS &&
               (trk_len < MIN_LENGTH || trk_len > 32'(cfg_max))) begin
            // rejected length: only the length is reported
            res.frame_status = STATUS_BAD_LENGTH;
            res.frame_length = trk_len;
            frame_results.push_back(res);
            trk_pos = 0;
         end else begin
            trk_pos++;
         end
      end else begin
         if (trk_pos == START_POS)
            trk_start_ok = (b == cfg_start);
         // summed part of the body, header captured inside it only
         if (trk_pos >= HDR_FIRST && trk_pos <= trk_len) begin
            trk_sum = trk_sum + 16'(b);
            if (trk_pos - HDR_FIRST < HDR_BYTES)
               trk_hdr[trk_pos - HDR_FIRST] = b;
         end
         if (trk_pos == trk_len + 1)
            trk_end_ok = (b == cfg_end);
         if (trk_pos == trk_len + 2)
            trk_sum_low = b;
         if (trk_pos == trk_len + 3) begin
            recv = {b, trk_sum_low};
            // bad start wins over bad end, bad end over checksum
            if (!trk_start_ok)
               res.frame_status = STATUS_BAD_START;
            else if (!trk_end_ok)
               res.frame_status = STATUS_BAD_END;
            else if (recv != trk_sum)
               res.frame_status = STATUS_BAD_SUM;
            else
               res.frame_status = STATUS_OK;
            res.datagram_id      = trk_hdr[0];
            res.model_number     = {trk_hdr[2], trk_hdr[1]};
            res.date_word        = {trk_hdr[6], trk_hdr[5], trk_hdr[4], trk_hdr[3]};
            res.millisecond_word = {trk_hdr[10], trk_hdr[9], trk_hdr[8], trk_hdr[7]};
            res.ping_number      = {trk_hdr[12], trk_hdr[11]};
            res.serial_word      = {trk_hdr[14], trk_hdr[13]};
            res.frame_length     = trk_len;
            res.computed_sum     = trk_sum;
            frame_results.push_back(res);
            trk_pos = 0;
         end else begin
            trk_pos++;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // stimulus building
   // ---------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] b);
      stream_bytes.push_back(b);
      bytes_queued++;
   endtask

   // a bare length field, used for rejected lengths
   task automatic queue_length(input logic [31:0] len);
      for (int k = 0; k < 4; k++)
         push_byte(len[8*k +: 8]);
   endtask

   // one complete datagram, with optional faults; high_fill pushes the sum to wrap
   task automatic queue_frame(input int unsigned len, input bit bad_start,
                              input bit bad_end, input bit bad_sum,
                              input bit high_fill);
      logic [15:0] sum;
      logic [7:0]  b;
      sum = '0;
      queue_length(32'(len));
      push_byte(bad_start ? cfg_start ^ 8'($urandom_range(1, 255)) : cfg_start);
      for (int unsigned p = 5; p <= len; p++) begin
         b = high_fill ? 8'($urandom_range(192, 255)) : 8'($urandom_range(0, 255));
         sum = sum + 16'(b);
         push_byte(b);
      end
      push_byte(bad_end ? cfg_end ^ 8'($urandom_range(1, 255)) : cfg_end);
      if (bad_sum)
         sum = sum ^ 16'($urandom_range(1, 65535));
      push_byte(sum[7:0]);
      push_byte(sum[15:8]);
   endtask

   // random datagram: mostly well formed, some with faults or a bad length
   task automatic queue_random_frame();
      int unsigned len;
      int          pick;
      int          faults;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         case ($urandom_range(0, 2))
            0:       queue_length(32'($urandom_range(0, 3)));
            1:       queue_length(32'(cfg_max) + 32'($urandom_range(1, 1000)));
            default: queue_length($urandom | 32'h0010_0000);
         endcase
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 60)
            len = $urandom_range(4, 24);
         else if (pick < 97)
            len = $urandom_range(20, 80);
         else
            len = $urandom_range(260, 600);
         if (len > cfg_max)
            len = $urandom_range(4, cfg_max);
         faults = ($urandom_range(0, 99) < 70) ? 0 : $urandom_range(1, 7);
         queue_frame(len, faults[0], faults[1], faults[2],
                     len >= 260 || $urandom_range(0, 9) == 0);
      end
   endtask

   // ---------------------------------------------------------------------
   // configuration and idle detection
   // ---------------------------------------------------------------------
   // nothing queued, nothing held on the input, nothing still to come out,
   // then a settling wait for the two-stage pipe to drain
   task automatic wait_idle(input int settle);
      while (stream_bytes.size() != 0 || req_valid || frame_results.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [LEN_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_START_MARKER: cfg_start = value[7:0];
         CSR_END_MARKER:   cfg_end   = value[7:0];
         CSR_MAX_LENGTH:   cfg_max   = value;
         default: ;
      endcase
   endtask

   task automatic check_field(input string field_name, input logic [31:0] wanted,
                              input logic [31:0] seen);
      if (seen !== wanted) begin
         if (mismatch_count < 10)
            $display("mismatch in %s: expected %0h, got %0h", field_name, wanted, seen);
         mismatch_count++;
      end
   endtask

   // ---------------------------------------------------------------------
   // driver: one byte per transfer, sent in bursts with gaps between them
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         // slot is free: either idle or the held byte was just taken
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (stream_bytes.size() != 0) begin
            req_valid     <= 1'b1;
            req_data_byte <= stream_bytes.pop_front();
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               // long bursts sometimes, and gaps of zero now and then
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                                        : $urandom_range(1, 20);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // input side monitor: every accepted byte goes through the frame tracker
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall)
            track_byte(req_data_byte);
      end
   end

   // ---------------------------------------------------------------------
   // receiver: stall pattern switches among free, random, heavy and periodic
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_mode_left == 0) begin
            stall_mode      = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(20, 200);
         end else begin
            stall_mode_left--;
         end
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= 1'($urandom_range(0, 1));
            2:       rsp_stall <= ($urandom_range(0, 9) < 8);
            default: rsp_stall <= ((stall_mode_left % 16) < 5);
         endcase
      end
   end

   // result side monitor: each transfer is checked against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_results.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected result: status %0d length %0h",
                        rsp_frame_status, rsp_frame_length);
            mismatch_count++;
         end else begin
            wanted_result = frame_results.pop_front();
            check_field("frame_status",     32'(wanted_result.frame_status), 32'(rsp_frame_status));
            check_field("datagram_id",      32'(wanted_result.datagram_id),  32'(rsp_datagram_id));
            check_field("model_number",     32'(wanted_result.model_number), 32'(rsp_model_number));
            check_field("date_word",        wanted_result.date_word,         rsp_date_word);
            check_field("millisecond_word", wanted_result.millisecond_word,  rsp_millisecond_word);
            check_field("ping_number",      32'(wanted_result.ping_number),  32'(rsp_ping_number));
            check_field("serial_word",      32'(wanted_result.serial_word),  32'(rsp_serial_word));
            check_field("frame_length",     wanted_result.frame_length,      rsp_frame_length);
            check_field("computed_sum",     32'(wanted_result.computed_sum), 32'(rsp_computed_sum));
         end
      end
   end

   // ---------------------------------------------------------------------
   // main sequence: reset, directed datagrams, then phases of random traffic
   // ---------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      req_data_byte    = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_START_MARKER;
      csr_write_data   = '0;
      bytes_queued     = 0;
      mismatch_count   = 0;
      burst_left       = 1;
      gap_left         = 0;
      stall_mode       = 0;
      stall_mode_left  = 0;
      trk_pos          = 0;
      trk_len          = '0;
      trk_sum          = '0;
      trk_start_ok     = 1'b0;
      trk_end_ok       = 1'b0;
      trk_sum_low      = '0;
      foreach (trk_hdr[i]) trk_hdr[i] = '0;
      cfg_start        = START_MARKER_RESET;
      cfg_end          = END_MARKER_RESET;
      cfg_max          = MAX_LENGTH_RESET;

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < 7; phase++) begin
         if (phase == 0) begin
            // directed: short length, all-ones length, the minimum datagram
            // and a datagram where every fault hits at once
            queue_length(32'd3);
            queue_length(32'hFFFF_FFFF);
            queue_frame(4, 1'b0, 1'b0, 1'b0, 1'b0);
            queue_frame(5, 1'b1, 1'b1, 1'b1, 1'b0);
         end else begin
            wait_idle(6);
            case (phase)
               1: begin
                  // smallest legal max length, all-zero and all-ones markers
                  write_csr(CSR_START_MARKER, 20'h00);
                  write_csr(CSR_END_MARKER,   20'hFF);
                  write_csr(CSR_MAX_LENGTH,   20'd4);
               end
               2: begin
                  write_csr(CSR_START_MARKER, 20'hFF);
                  write_csr(CSR_END_MARKER,   20'h00);
                  write_csr(CSR_MAX_LENGTH,   20'hFFFFF);
               end
               default: begin
                  // upper write data bits are don't-care for the markers
                  new_start = 8'($urandom);
                  new_end   = 8'($urandom);
                  new_max   = ($urandom_range(0, 1) == 0) ? 20'($urandom_range(4, 100))
                                                          : 20'($urandom_range(4, 20'hFFFFF));
                  write_csr(CSR_START_MARKER, {12'($urandom), new_start});
                  write_csr(CSR_END_MARKER,   {12'($urandom), new_end});
                  write_csr(CSR_MAX_LENGTH,   new_max);
               end
            endcase
         end
         // length limit edges: just over is rejected, exactly at it is accepted
         queue_length(32'(cfg_max) + 32'd1);
         if (cfg_max <= 600)
            queue_frame(cfg_max, 1'b0, 1'b0, 1'b0, 1'b0);
         phase_target = bytes_queued + 235;
         while (bytes_queued < phase_target)
            queue_random_frame();
      end

      wait_idle(20);
      if (mismatch_count == 0 && frame_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
